/* rtl/core/tbes_pkg.sv */
// Shared types, codes and the step micro-program for the two-body Euler step block.
// Used by tbes_ctrl, tbes_datapath and two_body_euler_step; depends on nothing.
package tbes_pkg;

  localparam int STEP_BITS    = 32;
  localparam int PC_BITS      = 6;
  localparam int CFG_IDX_BITS = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_GRAV  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DRAG  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TSTEP = 2'd2;

  // Request codes (bit 0 of req_type)
  localparam logic REQ_LOAD = 1'b0;

  // Micro-operations
  typedef enum logic [3:0] {
    OP_ADD, OP_SUB, OP_NEG, OP_HALF, OP_MUL, OP_SQ0, OP_SQ1,
    OP_DIV, OP_SQRT, OP_CHK, OP_END
  } op_t;

  // Operand / destination registers of the datapath
  typedef enum logic [4:0] {
    R_P0, R_P1, R_P2, R_P3, R_V0, R_V1, R_V2, R_V3,
    R_D0, R_D1, R_RR, R_T0, R_T1, R_T2,
    R_A0, R_A1, R_A2, R_A3, R_G, R_CD, R_DT, R_KE, R_PE
  } sel_t;

  typedef struct packed {
    op_t  op;
    sel_t dst;
    sel_t src_a;
    sel_t src_b;
  } instr_t;

  // Controller to datapath
  typedef struct packed {
    logic   start;
    logic   load;
    logic   out_load;
    logic   coll;
    instr_t instr;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic done;
    logic halted;
    logic r_zero;
  } status_t;

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_WAIT, ST_FIN} ctrl_state_t;

  function automatic instr_t mk_instr(op_t o, sel_t d, sel_t a, sel_t b);
    instr_t i;
    i.op    = o;
    i.dst   = d;
    i.src_a = a;
    i.src_b = b;
    return i;
  endfunction

  // One step: separation, length, central and drag terms, velocity and
  // position update, kinetic and potential energy.
  function automatic instr_t prog_word(logic [PC_BITS-1:0] pc);
    instr_t w;
    case (pc)
      6'd0:  w = mk_instr(OP_SUB,  R_D0, R_P0, R_P2);
      6'd1:  w = mk_instr(OP_SUB,  R_D1, R_P1, R_P3);
      6'd2:  w = mk_instr(OP_SQ0,  R_T0, R_D0, R_D0);
      6'd3:  w = mk_instr(OP_SQ1,  R_T0, R_D1, R_D1);
      6'd4:  w = mk_instr(OP_SQRT, R_RR, R_T0, R_T0);
      6'd5:  w = mk_instr(OP_CHK,  R_T0, R_T0, R_T0);
      // central term, x then y
      6'd6:  w = mk_instr(OP_MUL,  R_T0, R_G,  R_D0);
      6'd7:  w = mk_instr(OP_DIV,  R_T0, R_T0, R_RR);
      6'd8:  w = mk_instr(OP_DIV,  R_T0, R_T0, R_RR);
      6'd9:  w = mk_instr(OP_DIV,  R_T0, R_T0, R_RR);
      6'd10: w = mk_instr(OP_MUL,  R_T1, R_G,  R_D1);
      6'd11: w = mk_instr(OP_DIV,  R_T1, R_T1, R_RR);
      6'd12: w = mk_instr(OP_DIV,  R_T1, R_T1, R_RR);
      6'd13: w = mk_instr(OP_DIV,  R_T1, R_T1, R_RR);
      // accelerations with drag
      6'd14: w = mk_instr(OP_MUL,  R_A0, R_V0, R_V0);
      6'd15: w = mk_instr(OP_MUL,  R_A0, R_A0, R_CD);
      6'd16: w = mk_instr(OP_NEG,  R_T2, R_T0, R_T0);
      6'd17: w = mk_instr(OP_ADD,  R_A0, R_T2, R_A0);
      6'd18: w = mk_instr(OP_MUL,  R_A1, R_V1, R_V1);
      6'd19: w = mk_instr(OP_MUL,  R_A1, R_A1, R_CD);
      6'd20: w = mk_instr(OP_NEG,  R_T2, R_T1, R_T1);
      6'd21: w = mk_instr(OP_ADD,  R_A1, R_T2, R_A1);
      6'd22: w = mk_instr(OP_MUL,  R_A2, R_V2, R_V2);
      6'd23: w = mk_instr(OP_MUL,  R_A2, R_A2, R_CD);
      6'd24: w = mk_instr(OP_ADD,  R_A2, R_T0, R_A2);
      6'd25: w = mk_instr(OP_MUL,  R_A3, R_V3, R_V3);
      6'd26: w = mk_instr(OP_MUL,  R_A3, R_A3, R_CD);
      6'd27: w = mk_instr(OP_ADD,  R_A3, R_T1, R_A3);
      // velocity then position, per value
      6'd28: w = mk_instr(OP_MUL,  R_T2, R_A0, R_DT);
      6'd29: w = mk_instr(OP_ADD,  R_V0, R_V0, R_T2);
      6'd30: w = mk_instr(OP_MUL,  R_T2, R_V0, R_DT);
      6'd31: w = mk_instr(OP_ADD,  R_P0, R_P0, R_T2);
      6'd32: w = mk_instr(OP_MUL,  R_T2, R_A1, R_DT);
      6'd33: w = mk_instr(OP_ADD,  R_V1, R_V1, R_T2);
      6'd34: w = mk_instr(OP_MUL,  R_T2, R_V1, R_DT);
      6'd35: w = mk_instr(OP_ADD,  R_P1, R_P1, R_T2);
      6'd36: w = mk_instr(OP_MUL,  R_T2, R_A2, R_DT);
      6'd37: w = mk_instr(OP_ADD,  R_V2, R_V2, R_T2);
      6'd38: w = mk_instr(OP_MUL,  R_T2, R_V2, R_DT);
      6'd39: w = mk_instr(OP_ADD,  R_P2, R_P2, R_T2);
      6'd40: w = mk_instr(OP_MUL,  R_T2, R_A3, R_DT);
      6'd41: w = mk_instr(OP_ADD,  R_V3, R_V3, R_T2);
      6'd42: w = mk_instr(OP_MUL,  R_T2, R_V3, R_DT);
      6'd43: w = mk_instr(OP_ADD,  R_P3, R_P3, R_T2);
      // kinetic energy
      6'd44: w = mk_instr(OP_MUL,  R_T0, R_V0, R_V0);
      6'd45: w = mk_instr(OP_MUL,  R_T1, R_V1, R_V1);
      6'd46: w = mk_instr(OP_ADD,  R_T0, R_T0, R_T1);
      6'd47: w = mk_instr(OP_HALF, R_T0, R_T0, R_T0);
      6'd48: w = mk_instr(OP_MUL,  R_T1, R_V2, R_V2);
      6'd49: w = mk_instr(OP_MUL,  R_T2, R_V3, R_V3);
      6'd50: w = mk_instr(OP_ADD,  R_T1, R_T1, R_T2);
      6'd51: w = mk_instr(OP_HALF, R_T1, R_T1, R_T1);
      6'd52: w = mk_instr(OP_ADD,  R_KE, R_T0, R_T1);
      // potential energy
      6'd53: w = mk_instr(OP_DIV,  R_T0, R_G,  R_RR);
      6'd54: w = mk_instr(OP_NEG,  R_PE, R_T0, R_T0);
      default: w = mk_instr(OP_END, R_T0, R_T0, R_T0);
    endcase
    return w;
  endfunction

endpackage

/* rtl/core/tbes_ctrl.sv */
// Controller of the two-body Euler step: handshakes, program counter, result hand-off.
// Depends on tbes_pkg; drives tbes_datapath through cmd_t and reads status_t.
module tbes_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              req_type,
  output logic              out_valid,
  input  logic              out_stall,
  input  tbes_pkg::status_t status,
  output tbes_pkg::cmd_t    cmd
);

  tbes_pkg::ctrl_state_t           state, state_next;
  logic [tbes_pkg::PC_BITS-1:0]    pc, pc_next;
  logic                            coll, coll_next;
  logic                            out_valid_next;
  tbes_pkg::instr_t                instr;

  assign instr = tbes_pkg::prog_word(pc);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tbes_pkg::ST_IDLE;
      pc        <= '0;
      coll      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      pc        <= pc_next;
      coll      <= coll_next;
      out_valid <= out_valid_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next     = state;
    pc_next        = pc;
    coll_next      = coll;
    out_valid_next = out_valid && out_stall;
    in_stall       = 1'b1;
    cmd.start      = 1'b0;
    cmd.load       = 1'b0;
    cmd.out_load   = 1'b0;
    cmd.coll       = coll;
    cmd.instr      = instr;
    case (state)
      tbes_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (req_type == tbes_pkg::REQ_LOAD) begin
            cmd.load = 1'b1;
          end else begin
            pc_next    = '0;
            state_next = tbes_pkg::ST_RUN;
          end
        end
      end
      tbes_pkg::ST_RUN: begin
        if (instr.op == tbes_pkg::OP_CHK) begin
          // zero separation or already halted: collision result
          if (status.halted || status.r_zero) begin
            coll_next  = 1'b1;
            state_next = tbes_pkg::ST_FIN;
          end else begin
            pc_next = pc + 1'b1;
          end
        end else if (instr.op == tbes_pkg::OP_END) begin
          coll_next  = 1'b0;
          state_next = tbes_pkg::ST_FIN;
        end else begin
          cmd.start  = 1'b1;
          state_next = tbes_pkg::ST_WAIT;
        end
      end
      tbes_pkg::ST_WAIT: begin
        if (status.done) begin
          pc_next    = pc + 1'b1;
          state_next = tbes_pkg::ST_RUN;
        end
      end
      tbes_pkg::ST_FIN: begin
        // output register free or being taken this beat
        if (!out_valid || !out_stall) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = tbes_pkg::ST_IDLE;
        end
      end
      default: state_next = tbes_pkg::ST_IDLE;
    endcase
  end

endmodule

/* rtl/core/tbes_datapath.sv */
// Datapath of the two-body Euler step: body state, config, shared multiplier,
// restoring divider and square root unit, result registers. Depends on tbes_pkg.
module tbes_datapath #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  tbes_pkg::cmd_t                      cmd,
  output tbes_pkg::status_t                   status,
  input  logic signed [WORD_BITS-1:0]         load_pos [4],
  input  logic signed [WORD_BITS-1:0]         load_vel [4],
  input  logic                                cfg_we,
  input  logic [tbes_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [WORD_BITS-1:0]                cfg_data,
  output logic signed [WORD_BITS-1:0]         out_pos [4],
  output logic [WORD_BITS-2:0]                out_ke,
  output logic signed [WORD_BITS-1:0]         out_pe,
  output logic [tbes_pkg::STEP_BITS-1:0]      out_sc,
  output logic                                out_coll
);

  localparam int W     = WORD_BITS;
  localparam int F     = FRAC_BITS;
  localparam int QW    = W + F;
  localparam int MAG_W = (QW > 2 * W) ? QW : 2 * W;
  localparam int SQW   = 2 * W + 2;
  localparam int CNT_W = $clog2(QW + 1);
  localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [MAG_W-1:0] LIM_POS = (MAG_W'(1) << (W - 1)) - MAG_W'(1);
  localparam logic [MAG_W-1:0] LIM_NEG = MAG_W'(1) << (W - 1);
  localparam logic signed [W-1:0] G_RST  = W'(64'd1 << F);
  localparam logic [W-2:0]        DT_RST = (W-1)'((64'd1 << F) / 100);

  typedef enum logic [1:0] {U_IDLE, U_EXEC, U_ITER, U_WB} unit_t;

  // saturating helpers
  function automatic logic [W-1:0] mag(input logic signed [W-1:0] a);
    logic [W-1:0] u;
    u = a;
    return a[W-1] ? (~u + 1'b1) : u;
  endfunction

  function automatic logic signed [W-1:0] sadd(input logic signed [W-1:0] a,
                                               input logic signed [W-1:0] b);
    logic signed [W:0] s;
    s = {a[W-1], a} + {b[W-1], b};
    if (s[W] != s[W-1]) return s[W] ? VMIN : VMAX;
    return s[W-1:0];
  endfunction

  function automatic logic signed [W-1:0] ssub(input logic signed [W-1:0] a,
                                               input logic signed [W-1:0] b);
    logic signed [W:0] s;
    s = {a[W-1], a} - {b[W-1], b};
    if (s[W] != s[W-1]) return s[W] ? VMIN : VMAX;
    return s[W-1:0];
  endfunction

  function automatic logic signed [W-1:0] sat_mag(input logic neg,
                                                  input logic [MAG_W-1:0] m);
    if (neg) begin
      if (m > LIM_NEG) return VMIN;
      return ~m[W-1:0] + 1'b1;
    end
    if (m > LIM_POS) return VMAX;
    return m[W-1:0];
  endfunction

  // halve toward zero
  function automatic logic signed [W-1:0] halve(input logic signed [W-1:0] a);
    logic signed [W-1:0] s;
    s = a + {{(W-1){1'b0}}, a[W-1]};
    return s >>> 1;
  endfunction

  // body state and config
  logic signed [W-1:0]            pos [4];
  logic signed [W-1:0]            vel [4];
  logic signed [W-1:0]            grav, drag;
  logic [W-2:0]                   dstep;
  logic [tbes_pkg::STEP_BITS-1:0] steps_done;
  logic                           halted;

  // working registers
  logic signed [W-1:0] d0, d1, rr, t0, t1, t2, ke_r, pe_r;
  logic signed [W-1:0] acc [4];

  // unit registers
  unit_t               phase;
  tbes_pkg::op_t       op_q;
  tbes_pkg::sel_t      dst_q;
  logic signed [W-1:0] opa, opb;
  logic [2*W-1:0]      prod;
  logic [2*W:0]        sumsq;
  logic [SQW-1:0]      rad;
  logic [W+2:0]        srem;
  logic [W:0]          root;
  logic [QW-1:0]       num, quo;
  logic [W-1:0]        drem;
  logic [CNT_W-1:0]    cnt;

  logic signed [W-1:0] sel_a, sel_b, wb_val, rr_val;
  logic                wb_en, alu_op, iter_last, neg_q;
  logic [2*W-1:0]      prod_c;
  logic [W:0]          drem_sh, dvs;
  logic [W+4:0]        srem_sh, trial;

  // operand select
  always_comb begin
    case (cmd.instr.src_a)
      tbes_pkg::R_P0: sel_a = pos[0];
      tbes_pkg::R_P1: sel_a = pos[1];
      tbes_pkg::R_P2: sel_a = pos[2];
      tbes_pkg::R_P3: sel_a = pos[3];
      tbes_pkg::R_V0: sel_a = vel[0];
      tbes_pkg::R_V1: sel_a = vel[1];
      tbes_pkg::R_V2: sel_a = vel[2];
      tbes_pkg::R_V3: sel_a = vel[3];
      tbes_pkg::R_D0: sel_a = d0;
      tbes_pkg::R_D1: sel_a = d1;
      tbes_pkg::R_RR: sel_a = rr;
      tbes_pkg::R_T0: sel_a = t0;
      tbes_pkg::R_T1: sel_a = t1;
      tbes_pkg::R_T2: sel_a = t2;
      tbes_pkg::R_A0: sel_a = acc[0];
      tbes_pkg::R_A1: sel_a = acc[1];
      tbes_pkg::R_A2: sel_a = acc[2];
      tbes_pkg::R_A3: sel_a = acc[3];
      tbes_pkg::R_G:  sel_a = grav;
      tbes_pkg::R_CD: sel_a = drag;
      tbes_pkg::R_DT: sel_a = {1'b0, dstep};
      tbes_pkg::R_KE: sel_a = ke_r;
      tbes_pkg::R_PE: sel_a = pe_r;
      default:        sel_a = '0;
    endcase
  end

  always_comb begin
    case (cmd.instr.src_b)
      tbes_pkg::R_P0: sel_b = pos[0];
      tbes_pkg::R_P1: sel_b = pos[1];
      tbes_pkg::R_P2: sel_b = pos[2];
      tbes_pkg::R_P3: sel_b = pos[3];
      tbes_pkg::R_V0: sel_b = vel[0];
      tbes_pkg::R_V1: sel_b = vel[1];
      tbes_pkg::R_V2: sel_b = vel[2];
      tbes_pkg::R_V3: sel_b = vel[3];
      tbes_pkg::R_D0: sel_b = d0;
      tbes_pkg::R_D1: sel_b = d1;
      tbes_pkg::R_RR: sel_b = rr;
      tbes_pkg::R_T0: sel_b = t0;
      tbes_pkg::R_T1: sel_b = t1;
      tbes_pkg::R_T2: sel_b = t2;
      tbes_pkg::R_A0: sel_b = acc[0];
      tbes_pkg::R_A1: sel_b = acc[1];
      tbes_pkg::R_A2: sel_b = acc[2];
      tbes_pkg::R_A3: sel_b = acc[3];
      tbes_pkg::R_G:  sel_b = grav;
      tbes_pkg::R_CD: sel_b = drag;
      tbes_pkg::R_DT: sel_b = {1'b0, dstep};
      tbes_pkg::R_KE: sel_b = ke_r;
      tbes_pkg::R_PE: sel_b = pe_r;
      default:        sel_b = '0;
    endcase
  end

  // arithmetic around the unit registers
  assign alu_op    = op_q inside {tbes_pkg::OP_ADD, tbes_pkg::OP_SUB,
                                  tbes_pkg::OP_NEG, tbes_pkg::OP_HALF};
  assign neg_q     = opa[W-1] ^ opb[W-1];
  assign prod_c    = mag(opa) * mag(opb);
  assign dvs       = {1'b0, mag(opb)};
  assign drem_sh   = {drem, num[QW-1]};
  assign srem_sh   = {srem, rad[SQW-1 -: 2]};
  assign trial     = (W+5)'({root, 2'b01});
  assign iter_last = (op_q == tbes_pkg::OP_DIV) ? (cnt == CNT_W'(QW - 1))
                                                : (cnt == CNT_W'(W));
  assign rr_val    = (root[W:W-1] != 2'b00) ? VMAX : {1'b0, root[W-2:0]};

  // writeback value
  always_comb begin
    case (op_q)
      tbes_pkg::OP_ADD:  wb_val = sadd(opa, opb);
      tbes_pkg::OP_SUB:  wb_val = ssub(opa, opb);
      tbes_pkg::OP_NEG:  wb_val = ssub('0, opa);
      tbes_pkg::OP_HALF: wb_val = halve(opa);
      tbes_pkg::OP_MUL:  wb_val = sat_mag(neg_q, MAG_W'(prod >> F));
      tbes_pkg::OP_DIV:  wb_val = sat_mag(neg_q, MAG_W'(quo));
      tbes_pkg::OP_SQRT: wb_val = rr_val;
      default:           wb_val = '0;
    endcase
    wb_en = ((phase == U_EXEC) && alu_op) ||
            ((phase == U_WB) && !(op_q inside {tbes_pkg::OP_SQ0, tbes_pkg::OP_SQ1}));
  end

  assign status.done   = ((phase == U_EXEC) && alu_op) || (phase == U_WB);
  assign status.halted = halted;
  assign status.r_zero = (rr == '0);

  // unit sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= U_IDLE;
    end else begin
      case (phase)
        U_IDLE: if (cmd.start) phase <= U_EXEC;
        U_EXEC: begin
          if (alu_op) phase <= U_IDLE;
          else if (op_q inside {tbes_pkg::OP_DIV, tbes_pkg::OP_SQRT}) phase <= U_ITER;
          else phase <= U_WB;
        end
        U_ITER: if (iter_last) phase <= U_WB;
        U_WB:   phase <= U_IDLE;
        default: phase <= U_IDLE;
      endcase
    end
  end

  // body state, step count, config
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        pos[i] <= '0;
        vel[i] <= '0;
      end
      steps_done <= '0;
      halted     <= 1'b0;
      grav       <= G_RST;
      drag       <= '0;
      dstep      <= DT_RST;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          tbes_pkg::CFG_GRAV:  grav  <= cfg_data;
          tbes_pkg::CFG_DRAG:  drag  <= cfg_data;
          tbes_pkg::CFG_TSTEP: dstep <= cfg_data[W-2:0];
          default: ;
        endcase
      end
      if (cmd.load) begin
        for (int i = 0; i < 4; i++) begin
          pos[i] <= load_pos[i];
          vel[i] <= load_vel[i];
        end
        steps_done <= '0;
        halted     <= 1'b0;
      end
      if (wb_en) begin
        case (dst_q)
          tbes_pkg::R_P0: pos[0] <= wb_val;
          tbes_pkg::R_P1: pos[1] <= wb_val;
          tbes_pkg::R_P2: pos[2] <= wb_val;
          tbes_pkg::R_P3: pos[3] <= wb_val;
          tbes_pkg::R_V0: vel[0] <= wb_val;
          tbes_pkg::R_V1: vel[1] <= wb_val;
          tbes_pkg::R_V2: vel[2] <= wb_val;
          tbes_pkg::R_V3: vel[3] <= wb_val;
          default: ;
        endcase
      end
      if (cmd.out_load) begin
        if (cmd.coll) halted <= 1'b1;
        else steps_done <= steps_done + 1'b1;
      end
    end
  end

  // working registers, iterative units, result registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_q  <= cmd.instr.op;
      dst_q <= cmd.instr.dst;
      opa   <= sel_a;
      opb   <= sel_b;
    end
    if (phase == U_EXEC) begin
      prod <= prod_c;
      cnt  <= '0;
      num  <= {mag(opa), {F{1'b0}}};
      quo  <= '0;
      drem <= '0;
      rad  <= SQW'(sumsq);
      srem <= '0;
      root <= '0;
    end
    // one quotient bit or one root bit per cycle
    if (phase == U_ITER) begin
      cnt <= cnt + 1'b1;
      if (op_q == tbes_pkg::OP_DIV) begin
        num <= num << 1;
        if (drem_sh >= dvs) begin
          drem <= W'(drem_sh - dvs);
          quo  <= {quo[QW-2:0], 1'b1};
        end else begin
          drem <= drem_sh[W-1:0];
          quo  <= {quo[QW-2:0], 1'b0};
        end
      end else begin
        rad <= rad << 2;
        if (srem_sh >= trial) begin
          srem <= (W+3)'(srem_sh - trial);
          root <= {root[W-1:0], 1'b1};
        end else begin
          srem <= srem_sh[W+2:0];
          root <= {root[W-1:0], 1'b0};
        end
      end
    end
    // sum of squared separations
    if (phase == U_WB) begin
      if (op_q == tbes_pkg::OP_SQ0) sumsq <= {1'b0, prod};
      else if (op_q == tbes_pkg::OP_SQ1) sumsq <= sumsq + {1'b0, prod};
    end
    if (wb_en) begin
      case (dst_q)
        tbes_pkg::R_D0: d0     <= wb_val;
        tbes_pkg::R_D1: d1     <= wb_val;
        tbes_pkg::R_RR: rr     <= wb_val;
        tbes_pkg::R_T0: t0     <= wb_val;
        tbes_pkg::R_T1: t1     <= wb_val;
        tbes_pkg::R_T2: t2     <= wb_val;
        tbes_pkg::R_A0: acc[0] <= wb_val;
        tbes_pkg::R_A1: acc[1] <= wb_val;
        tbes_pkg::R_A2: acc[2] <= wb_val;
        tbes_pkg::R_A3: acc[3] <= wb_val;
        tbes_pkg::R_KE: ke_r   <= wb_val;
        tbes_pkg::R_PE: pe_r   <= wb_val;
        default: ;
      endcase
    end
    if (cmd.out_load) begin
      for (int i = 0; i < 4; i++) out_pos[i] <= pos[i];
      out_ke   <= cmd.coll ? '0 : ke_r[W-2:0];
      out_pe   <= cmd.coll ? '0 : pe_r;
      out_sc   <= steps_done;
      out_coll <= cmd.coll;
    end
  end

endmodule

/* rtl/core/two_body_euler_step.sv */
// Two-body gravity semi-implicit Euler step, top level.
// Input channel (in_valid/in_stall): req_type 0 loads the eight position and
//   velocity words and gives no result; req_type 1 advances one step and
//   gives one result beat on the output channel (out_valid/out_stall).
// Config channel (cfg_valid/cfg_ready, always ready): index 0 G, 1 drag
//   coefficient, 2 time step; other indexes are dropped. Write only when idle.
// Operation: a step runs a micro-program on one shared multiplier, a
//   one-bit-per-cycle restoring divider and a two-bit-per-cycle square root;
//   seven quotients of WORD_BITS+FRAC_BITS bits dominate. Collision steps end
//   after the square root.
// Throughput: one item at a time; in_stall is high while a step runs.
// The result sits in an output register: while the receiver stalls, the next
//   item is still accepted and runs, and only its hand-off waits.
// Reset: all positions, velocities, step count and halt flag clear, G = 1.0,
//   drag 0, time step 655; a step before any load reports a collision.
// Depends on tbes_pkg, tbes_ctrl and tbes_datapath.
module two_body_euler_step #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              req_type,
  input  logic signed [WORD_BITS-1:0]       load_pos_a_x,
  input  logic signed [WORD_BITS-1:0]       load_pos_a_y,
  input  logic signed [WORD_BITS-1:0]       load_pos_b_x,
  input  logic signed [WORD_BITS-1:0]       load_pos_b_y,
  input  logic signed [WORD_BITS-1:0]       load_vel_a_x,
  input  logic signed [WORD_BITS-1:0]       load_vel_a_y,
  input  logic signed [WORD_BITS-1:0]       load_vel_b_x,
  input  logic signed [WORD_BITS-1:0]       load_vel_b_y,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [WORD_BITS-1:0]       out_pos_a_x,
  output logic signed [WORD_BITS-1:0]       out_pos_a_y,
  output logic signed [WORD_BITS-1:0]       out_pos_b_x,
  output logic signed [WORD_BITS-1:0]       out_pos_b_y,
  output logic [WORD_BITS-2:0]              kinetic_energy,
  output logic signed [WORD_BITS-1:0]       potential_energy,
  output logic [tbes_pkg::STEP_BITS-1:0]    step_count,
  output logic                              collided,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tbes_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [WORD_BITS-1:0]              cfg_data
);

  tbes_pkg::cmd_t            cmd;
  tbes_pkg::status_t         status;
  logic signed [WORD_BITS-1:0] load_pos [4];
  logic signed [WORD_BITS-1:0] load_vel [4];
  logic signed [WORD_BITS-1:0] out_pos [4];

  assign cfg_ready = 1'b1;

  // load beat, body order A.x A.y B.x B.y
  assign load_pos[0] = load_pos_a_x;
  assign load_pos[1] = load_pos_a_y;
  assign load_pos[2] = load_pos_b_x;
  assign load_pos[3] = load_pos_b_y;
  assign load_vel[0] = load_vel_a_x;
  assign load_vel[1] = load_vel_a_y;
  assign load_vel[2] = load_vel_b_x;
  assign load_vel[3] = load_vel_b_y;

  assign out_pos_a_x = out_pos[0];
  assign out_pos_a_y = out_pos[1];
  assign out_pos_b_x = out_pos[2];
  assign out_pos_b_y = out_pos[3];

  tbes_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .req_type  (req_type),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  tbes_datapath #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .load_pos  (load_pos),
    .load_vel  (load_vel),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_pos   (out_pos),
    .out_ke    (kinetic_energy),
    .out_pe    (potential_energy),
    .out_sc    (step_count),
    .out_coll  (collided)
  );

endmodule
